// ===== design/assert_macros.svh =====
// Assertion helpers for the port checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("port check failed");

// Trigger implies a consequence at the next edge
`define CHK_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("port check failed");

`endif

// ===== design/pmvm_pkg.sv =====
`default_nettype none
package pmvm_pkg;

    localparam int POLY_DEGREE_DEFAULT = 256;
    localparam int RANK_DEFAULT        = 3;
    localparam int COEFF_WIDTH_DEFAULT = 13;

    localparam int MODE_W    = 2;
    localparam int INDEX_W   = 12;
    localparam int COEF_W    = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    localparam logic [MODE_W-1:0] MODE_WR_MAT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_VEC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS         = 1'd1;

    localparam logic [3:0] MODULUS_BITS_RESET = 4'd13;
    localparam logic [1:0] ROWS_RESET         = 2'd3;

    // chain control, one step per cycle
    typedef struct packed {
        logic load_b;
        logic mac;
        logic drain;
    } ctl_t;

endpackage
`default_nettype wire

// ===== design/poly_matrix_vector_multiply.sv =====
// Negacyclic polynomial matrix-vector multiply over a chain of POLY_DEGREE cells. Matrix and
// vector writes and result reads are accepted, one every cycle, while the block is idle and
// its output is not stalled. A compute item holds the input side while, per row and column,
// the vector polynomial is shifted into the chain, then one matrix coefficient is broadcast
// per cycle for the multiply-accumulate; after the last column the row is drained into the
// result memory. Result rows that were never computed read as zero.
`default_nettype none
module poly_matrix_vector_multiply #(
    parameter int POLY_DEGREE = pmvm_pkg::POLY_DEGREE_DEFAULT,
    parameter int RANK        = pmvm_pkg::RANK_DEFAULT,
    parameter int COEFF_WIDTH = pmvm_pkg::COEFF_WIDTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [31:0]                      s_tdata,  // index[11:0], coefficient[24:12]
    input  wire logic [pmvm_pkg::MODE_W-1:0]      s_tuser,  // mode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [15:0]                      m_tdata,  // read_value[12:0]
    output logic                                  m_tuser,  // bad_index
    input  wire logic                             cfg_wr_en,
    input  wire logic [pmvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pmvm_pkg::CFG_DAT_W-1:0]   cfg_data
);

    localparam int W         = COEFF_WIDTH;
    localparam int MAT_DEPTH = RANK * RANK * POLY_DEGREE;
    localparam int VEC_DEPTH = RANK * POLY_DEGREE;
    localparam int MAW       = $clog2(MAT_DEPTH);
    localparam int VAW       = $clog2(VEC_DEPTH);
    localparam int KW        = $clog2(POLY_DEGREE);
    localparam int RW        = $clog2(RANK);
    localparam int RCW       = $clog2(RANK + 1);
    localparam int MBW       = $clog2(W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOADB,
        ST_MAC,
        ST_DRAIN
    } state_t;

    state_t           state_reg, state_next;
    logic [KW-1:0]    cnt_reg, cnt_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [RW-1:0]    col_reg, col_next;
    logic [RANK-1:0]  rvalid_reg, rvalid_next;
    pmvm_pkg::ctl_t   ctl_issue, ctl_reg;
    logic [VAW-1:0]   waddr_issue, waddr_reg;

    logic [3:0]       modulus_reg;
    logic [1:0]       rows_reg;
    logic [MBW-1:0]   mbits;
    logic [W-1:0]     mask;
    logic [RCW-1:0]   nrows;

    logic [W-1:0]     mat_mem [MAT_DEPTH];
    logic [W-1:0]     vec_mem [VEC_DEPTH];
    logic [W-1:0]     res_mem [VEC_DEPTH];
    logic [W-1:0]     mat_rdata_reg, vec_rdata_reg, res_rdata_reg;
    logic [MAW-1:0]   mat_raddr;
    logic [VAW-1:0]   vec_raddr;
    logic [W-1:0]     acc_last;

    logic [pmvm_pkg::MODE_W-1:0]  mode;
    logic [pmvm_pkg::INDEX_W-1:0] idx;
    logic [pmvm_pkg::COEF_W-1:0]  coef;
    logic [W-1:0]                 coef_masked;
    logic                         accept;
    logic                         mat_ok, vec_ok, row_hit;
    logic                         out_valid_reg, out_bad_reg, out_rd_reg;
    logic                         last_k;

    assign mode   = s_tuser;
    assign idx    = s_tdata[11:0];
    assign coef   = s_tdata[24:12];
    assign accept = s_tvalid && s_tready;
    assign mat_ok = {1'b0, idx} < 13'(MAT_DEPTH);
    assign vec_ok = {1'b0, idx} < 13'(VEC_DEPTH);

    assign mbits = ({1'b0, modulus_reg} > 5'(W)) ? MBW'(W) : MBW'(modulus_reg);
    assign mask  = {W{1'b1}} >> (MBW'(W) - mbits);
    assign nrows = ({1'b0, rows_reg} > 3'(RANK)) ? RCW'(RANK) : RCW'(rows_reg);
    assign coef_masked = W'(coef) & mask;

    assign s_tready = (state_reg == ST_IDLE) && (ctl_reg == '0) && (!out_valid_reg || m_tready);
    assign last_k   = (cnt_reg == KW'(POLY_DEGREE - 1));

    always_comb
    begin
        row_hit = 1'b0;
        for (int r = 0; r < RANK; r++)
        begin
            if ({1'b0, idx} >= 13'(r * POLY_DEGREE) && {1'b0, idx} < 13'((r + 1) * POLY_DEGREE)
                && rvalid_reg[r])
            begin
                row_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        rvalid_next = rvalid_reg;
        ctl_issue   = '0;
        vec_raddr   = VAW'(32'(col_reg) * POLY_DEGREE + (POLY_DEGREE - 1) - 32'(cnt_reg));
        mat_raddr   = MAW'((32'(row_reg) * RANK + 32'(col_reg)) * POLY_DEGREE + 32'(cnt_reg));
        waddr_issue = VAW'(32'(row_reg) * POLY_DEGREE + (POLY_DEGREE - 1) - 32'(cnt_reg));
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == pmvm_pkg::MODE_COMPUTE)
                begin
                    rvalid_next = '0;
                    cnt_next    = '0;
                    row_next    = '0;
                    col_next    = '0;
                    if (nrows != '0)
                    begin
                        state_next = ST_LOADB;
                    end
                end
            end
            ST_LOADB:
            begin
                ctl_issue.load_b = 1'b1;
                cnt_next = last_k ? '0 : cnt_reg + 1'b1;
                if (last_k)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                ctl_issue.mac = 1'b1;
                cnt_next = last_k ? '0 : cnt_reg + 1'b1;
                if (last_k)
                begin
                    if (col_reg == RW'(RANK - 1))
                    begin
                        col_next   = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = ST_LOADB;
                    end
                end
            end
            ST_DRAIN:
            begin
                ctl_issue.drain      = 1'b1;
                rvalid_next[row_reg] = 1'b1;
                cnt_next = last_k ? '0 : cnt_reg + 1'b1;
                if (last_k)
                begin
                    if (RCW'(row_reg) == nrows - 1'b1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_LOADB;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            rvalid_reg    <= '0;
            ctl_reg       <= '0;
            modulus_reg   <= pmvm_pkg::MODULUS_BITS_RESET;
            rows_reg      <= pmvm_pkg::ROWS_RESET;
            out_valid_reg <= 1'b0;
            out_bad_reg   <= 1'b0;
            out_rd_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            rvalid_reg <= rvalid_next;
            ctl_reg    <= ctl_issue;
            if (cfg_wr_en && cfg_index == pmvm_pkg::REG_MODULUS_BITS)
            begin
                modulus_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == pmvm_pkg::REG_ROWS)
            begin
                rows_reg <= cfg_data[1:0];
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                case (mode)
                    pmvm_pkg::MODE_WR_MAT:
                    begin
                        out_bad_reg <= !mat_ok;
                        out_rd_reg  <= 1'b0;
                    end
                    pmvm_pkg::MODE_WR_VEC:
                    begin
                        out_bad_reg <= !vec_ok;
                        out_rd_reg  <= 1'b0;
                    end
                    pmvm_pkg::MODE_READ:
                    begin
                        out_bad_reg <= !vec_ok;
                        out_rd_reg  <= vec_ok && row_hit;
                    end
                    default:
                    begin
                        out_bad_reg <= 1'b0;
                        out_rd_reg  <= 1'b0;
                    end
                endcase
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg     <= waddr_issue;
        mat_rdata_reg <= mat_mem[mat_raddr];
        vec_rdata_reg <= vec_mem[vec_raddr];
        if (accept && mode == pmvm_pkg::MODE_WR_MAT && mat_ok)
        begin
            mat_mem[idx[MAW-1:0]] <= coef_masked;
        end
        if (accept && mode == pmvm_pkg::MODE_WR_VEC && vec_ok)
        begin
            vec_mem[idx[VAW-1:0]] <= coef_masked;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mode == pmvm_pkg::MODE_READ && vec_ok)
        begin
            res_rdata_reg <= res_mem[idx[VAW-1:0]];
        end
        if (ctl_reg.drain)
        begin
            res_mem[waddr_reg] <= acc_last & mask;
        end
    end

    pmvm_chain #(
        .POLY_DEGREE(POLY_DEGREE),
        .COEFF_WIDTH(COEFF_WIDTH)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_reg),
        .a       (mat_rdata_reg),
        .v_in    (vec_rdata_reg),
        .acc_last(acc_last)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_bad_reg;
    assign m_tdata  = {3'b000, out_rd_reg ? pmvm_pkg::COEF_W'(res_rdata_reg)
                                          : {pmvm_pkg::COEF_W{1'b0}}};

endmodule
`default_nettype wire

// ===== design/pmvm_cell.sv =====
`default_nettype none
module pmvm_cell #(
    parameter int COEFF_WIDTH = pmvm_pkg::COEFF_WIDTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pmvm_pkg::ctl_t         ctl,
    input  wire logic [COEFF_WIDTH-1:0] a,
    input  wire logic [COEFF_WIDTH-1:0] b_in,
    input  wire logic [COEFF_WIDTH-1:0] acc_in,
    output logic      [COEFF_WIDTH-1:0] b_out,
    output logic      [COEFF_WIDTH-1:0] acc_out
);

    logic [COEFF_WIDTH-1:0]   b_reg;
    logic [COEFF_WIDTH-1:0]   acc_reg;
    logic [COEFF_WIDTH-1:0]   acc_next;
    logic [2*COEFF_WIDTH-1:0] prod;

    assign prod = a * b_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.mac)
        begin
            acc_next = acc_reg + prod[COEFF_WIDTH-1:0];
        end
        else if (ctl.drain)
        begin
            acc_next = acc_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_b || ctl.mac)
        begin
            b_reg <= b_in;
        end
    end

    assign b_out   = b_reg;
    assign acc_out = acc_reg;

endmodule
`default_nettype wire

// ===== design/pmvm_chain.sv =====
`default_nettype none
module pmvm_chain #(
    parameter int POLY_DEGREE = pmvm_pkg::POLY_DEGREE_DEFAULT,
    parameter int COEFF_WIDTH = pmvm_pkg::COEFF_WIDTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pmvm_pkg::ctl_t         ctl,
    input  wire logic [COEFF_WIDTH-1:0] a,
    input  wire logic [COEFF_WIDTH-1:0] v_in,
    output logic      [COEFF_WIDTH-1:0] acc_last
);

    logic [COEFF_WIDTH-1:0] b_link   [POLY_DEGREE];
    logic [COEFF_WIDTH-1:0] acc_link [POLY_DEGREE];
    logic [COEFF_WIDTH-1:0] b_head;

    // negacyclic wrap: x^N = -1
    assign b_head = ctl.load_b ? v_in : ({COEFF_WIDTH{1'b0}} - b_link[POLY_DEGREE-1]);

    for (genvar k = 0; k < POLY_DEGREE; k++)
    begin : g_cell
        pmvm_cell #(
            .COEFF_WIDTH(COEFF_WIDTH)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .a      (a),
            .b_in   ((k == 0) ? b_head : b_link[(k == 0) ? 0 : k-1]),
            .acc_in ((k == 0) ? {COEFF_WIDTH{1'b0}} : acc_link[(k == 0) ? 0 : k-1]),
            .b_out  (b_link[k]),
            .acc_out(acc_link[k])
        );
    end

    assign acc_last = acc_link[POLY_DEGREE-1];

endmodule
`default_nettype wire

// ===== design/pmvm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module pmvm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);

    `CHK_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `CHK_ASSERT_NEXT(a_one_result, clk, rst_n, s_tvalid && s_tready, m_tvalid)
    `CHK_ASSERT(a_bad_zero, clk, rst_n, !(m_tvalid && m_tuser) || m_tdata == 16'd0)
    `CHK_ASSERT_NEXT(a_compute_out, clk, rst_n,
        s_tvalid && s_tready && s_tuser == pmvm_pkg::MODE_COMPUTE,
        !m_tuser && m_tdata == 16'd0)

endmodule

bind poly_matrix_vector_multiply pmvm_checker u_pmvm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
`default_nettype wire
